FILE: sv/config_text_tokenizer_top_defines.svh
// Assertion macros shared by the tokenizer RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef CONFIG_TEXT_TOKENIZER_TOP_DEFINES_SVH
`define CONFIG_TEXT_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define CTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/ctt_pkg.sv
// Types and constants shared by the tokenizer front end, back end and top level.
// No dependencies.
`default_nettype none

package ctt_pkg;

  // Result field widths.
  localparam int TOK_BITS = 24;
  localparam logic [TOK_BITS-1:0] TOK_MAX = {TOK_BITS{1'b1}};

  // Queue between front and back end; depth must be a power of two.
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = QPTR_BITS + 1;

  // Character codes.
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CH_LOWER_A = 8'd97;
  localparam logic [7:0] CH_LOWER_Z = 8'd122;
  localparam logic [7:0] CH_UNDER   = 8'd95;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;

  // Token kinds as they appear on the result channel.
  typedef enum logic [3:0] {
    KIND_IDENT   = 4'd0,
    KIND_VALUE   = 4'd1,
    KIND_NUMBER  = 4'd2,
    KIND_LT      = 4'd3,
    KIND_GT      = 4'd4,
    KIND_LBRACE  = 4'd5,
    KIND_RBRACE  = 4'd6,
    KIND_EQ      = 4'd7,
    KIND_SEMI    = 4'd8,
    KIND_COMMA   = 4'd9,
    KIND_SLASH   = 4'd10,
    KIND_COMMENT = 4'd11,
    KIND_END     = 4'd12,
    KIND_ERROR   = 4'd13
  } token_kind_t;

  // Character classes produced by the front end.
  typedef enum logic [3:0] {
    CLS_WS,
    CLS_HEAD,
    CLS_DIGIT,
    CLS_MINUS,
    CLS_DOT,
    CLS_QUOTE,
    CLS_SLASH,
    CLS_STAR,
    CLS_PUNCT,
    CLS_OTHER,
    CLS_END
  } char_class_t;

  // Lexer modes held by the back end.
  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMINT,
    MODE_NUMFRAC,
    MODE_VALUE,
    MODE_SLASH,
    MODE_COMMENT,
    MODE_CSTAR,
    MODE_ERROR
  } lex_mode_t;

  // One classified word in the queue.
  typedef struct packed {
    char_class_t cls;
    token_kind_t punct;
  } q_item_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  // One result token.
  typedef struct packed {
    token_kind_t         kind;
    logic [TOK_BITS-1:0] start;
    logic [TOK_BITS-1:0] length;
    logic                last;
  } token_t;

endpackage

`default_nettype wire

FILE: sv/ctt_front.sv
// Tokenizer front end: accepts input words, classifies each character and
// queues the class for the back end. Depends on ctt_pkg.
`default_nettype none

module ctt_front (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [7:0]         in_char_byte,
  input  wire                in_end_of_stream,
  output ctt_pkg::q_head_t   q_head,
  input  wire                q_pop
);
  import ctt_pkg::*;

  q_item_t                mem [QDEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0]   count_r, count_nxt;
  q_item_t                cls_item;
  logic                   push;
  logic                   pop;

  // Classify the incoming character.
  always_comb begin
    cls_item.punct = KIND_ERROR;
    cls_item.cls   = CLS_OTHER;
    if (in_end_of_stream) begin
      cls_item.cls = CLS_END;
    end else if ((in_char_byte >= CH_UPPER_A && in_char_byte <= CH_UPPER_Z) ||
                 (in_char_byte >= CH_LOWER_A && in_char_byte <= CH_LOWER_Z) ||
                 in_char_byte == CH_UNDER) begin
      cls_item.cls = CLS_HEAD;
    end else if (in_char_byte >= CH_ZERO && in_char_byte <= CH_NINE) begin
      cls_item.cls = CLS_DIGIT;
    end else begin
      unique case (in_char_byte)
        CH_SPACE, CH_TAB, CH_NL: cls_item.cls = CLS_WS;
        CH_MINUS:  cls_item.cls = CLS_MINUS;
        CH_DOT:    cls_item.cls = CLS_DOT;
        CH_QUOTE:  cls_item.cls = CLS_QUOTE;
        CH_SLASH:  cls_item.cls = CLS_SLASH;
        CH_STAR:   cls_item.cls = CLS_STAR;
        CH_SEMI: begin
          cls_item.cls   = CLS_PUNCT;
          cls_item.punct = KIND_SEMI;
        end
        CH_EQ: begin
          cls_item.cls   = CLS_PUNCT;
          cls_item.punct = KIND_EQ;
        end
        CH_LBRACE: begin
          cls_item.cls   = CLS_PUNCT;
          cls_item.punct = KIND_LBRACE;
        end
        CH_RBRACE: begin
          cls_item.cls   = CLS_PUNCT;
          cls_item.punct = KIND_RBRACE;
        end
        CH_LT: begin
          cls_item.cls   = CLS_PUNCT;
          cls_item.punct = KIND_LT;
        end
        CH_GT: begin
          cls_item.cls   = CLS_PUNCT;
          cls_item.punct = KIND_GT;
        end
        CH_COMMA: begin
          cls_item.cls   = CLS_PUNCT;
          cls_item.punct = KIND_COMMA;
        end
        default: cls_item.cls = CLS_OTHER;
      endcase
    end
  end

  // Queue control: stall the input side only when the queue is full.
  always_comb begin
    in_stall     = (count_r == QCNT_BITS'(QDEPTH));
    push         = in_valid && !in_stall;
    pop          = q_pop && (count_r != '0);
    wr_ptr_nxt   = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt   = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt    = count_r + QCNT_BITS'(push) - QCNT_BITS'(pop);
    q_head.valid = (count_r != '0);
    q_head.item  = mem[rd_ptr_r];
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= cls_item;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ctt_back.sv
// Tokenizer back end: runs the lexer on classified words and drives the
// result register plus a spill slot for a second token. Depends on ctt_pkg.
`default_nettype none

module ctt_back #(
  parameter int POS_BITS = 24
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  ctt_pkg::q_head_t             q_head,
  output logic                         q_pop,
  output logic                         out_valid,
  input  wire                          out_stall,
  output ctt_pkg::token_t              out_tok
);
  import ctt_pkg::*;

  localparam int WB = (POS_BITS > TOK_BITS) ? POS_BITS : TOK_BITS;

  lex_mode_t            mode_r, mode_nxt;
  logic [POS_BITS-1:0]  begin_r, begin_nxt;
  logic [POS_BITS-1:0]  pos_r, pos_nxt;
  token_t               out_r;
  logic                 out_valid_r;
  token_t               spill_r;
  logic                 spill_valid_r;

  logic [POS_BITS-1:0]  pend;
  logic [POS_BITS-1:0]  pos_p1;
  logic                 st_v;
  token_kind_t          st_kind;
  lex_mode_t            st_mode;
  logic                 st_begin_we;
  logic [POS_BITS-1:0]  st_begin;
  logic                 use_start;
  logic                 pre_v;
  token_kind_t          pre_kind;
  logic [POS_BITS-1:0]  pre_len;
  logic                 post_v;
  token_t               pre_tok;
  token_t               post_tok;
  token_t               tok0;
  token_t               tok1;
  logic                 two_tok;
  logic                 any_tok;
  logic                 out_free;

  // Length modulo the offset width, saturated to the result width.
  function automatic logic [TOK_BITS-1:0] sat_len(input logic [POS_BITS-1:0] len);
    logic [WB-1:0] w;
    w = WB'(len);
    if (w > WB'(TOK_MAX)) begin
      return TOK_MAX;
    end
    return w[TOK_BITS-1:0];
  endfunction

  // Low result-width bits of an offset.
  function automatic logic [TOK_BITS-1:0] low_pos(input logic [POS_BITS-1:0] p);
    logic [WB-1:0] w;
    w = WB'(p);
    return w[TOK_BITS-1:0];
  endfunction

  // What a character does when it opens a new token.
  always_comb begin
    pos_p1      = pos_r + POS_BITS'(1);
    pend        = pos_r - begin_r;
    st_v        = 1'b0;
    st_kind     = KIND_ERROR;
    st_mode     = MODE_IDLE;
    st_begin_we = 1'b0;
    st_begin    = pos_r;
    unique case (q_head.item.cls)
      CLS_PUNCT: begin
        st_v    = 1'b1;
        st_kind = q_head.item.punct;
      end
      CLS_WS: begin
        st_mode = MODE_IDLE;
      end
      CLS_SLASH: begin
        st_mode     = MODE_SLASH;
        st_begin_we = 1'b1;
      end
      CLS_QUOTE: begin
        st_mode     = MODE_VALUE;
        st_begin_we = 1'b1;
        st_begin    = pos_p1;
      end
      CLS_DIGIT, CLS_MINUS: begin
        st_mode     = MODE_NUMINT;
        st_begin_we = 1'b1;
      end
      CLS_HEAD: begin
        st_mode     = MODE_IDENT;
        st_begin_we = 1'b1;
      end
      default: begin
        st_v    = 1'b1;
        st_kind = KIND_ERROR;
        st_mode = MODE_ERROR;
      end
    endcase
  end

  // Lexer step: the pending token it closes and the state it leaves.
  always_comb begin
    use_start = 1'b0;
    pre_v     = 1'b0;
    pre_kind  = KIND_IDENT;
    pre_len   = pend;
    mode_nxt  = mode_r;
    begin_nxt = begin_r;
    pos_nxt   = pos_p1;
    if (q_head.item.cls == CLS_END) begin
      // End of stream flushes the pending token and restarts offsets.
      unique case (mode_r)
        MODE_IDENT: begin
          pre_v    = 1'b1;
          pre_kind = KIND_IDENT;
        end
        MODE_NUMINT, MODE_NUMFRAC: begin
          pre_v    = 1'b1;
          pre_kind = KIND_NUMBER;
        end
        MODE_VALUE: begin
          pre_v    = 1'b1;
          pre_kind = KIND_VALUE;
        end
        MODE_SLASH: begin
          pre_v    = 1'b1;
          pre_kind = KIND_SLASH;
          pre_len  = POS_BITS'(1);
        end
        MODE_COMMENT, MODE_CSTAR: begin
          pre_v    = 1'b1;
          pre_kind = KIND_COMMENT;
        end
        default: pre_v = 1'b0;
      endcase
      mode_nxt  = MODE_IDLE;
      begin_nxt = '0;
      pos_nxt   = '0;
    end else begin
      unique case (mode_r)
        MODE_IDENT: begin
          if (q_head.item.cls != CLS_HEAD && q_head.item.cls != CLS_DIGIT) begin
            pre_v     = 1'b1;
            pre_kind  = KIND_IDENT;
            use_start = 1'b1;
          end
        end
        MODE_NUMINT: begin
          if (q_head.item.cls == CLS_DOT) begin
            mode_nxt = MODE_NUMFRAC;
          end else if (q_head.item.cls != CLS_DIGIT) begin
            pre_v     = 1'b1;
            pre_kind  = KIND_NUMBER;
            use_start = 1'b1;
          end
        end
        MODE_NUMFRAC: begin
          if (q_head.item.cls != CLS_DIGIT) begin
            pre_v     = 1'b1;
            pre_kind  = KIND_NUMBER;
            use_start = 1'b1;
          end
        end
        MODE_VALUE: begin
          if (q_head.item.cls == CLS_QUOTE) begin
            pre_v    = 1'b1;
            pre_kind = KIND_VALUE;
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_SLASH: begin
          if (q_head.item.cls == CLS_STAR) begin
            mode_nxt  = MODE_COMMENT;
            begin_nxt = pos_p1;
          end else begin
            pre_v     = 1'b1;
            pre_kind  = KIND_SLASH;
            pre_len   = POS_BITS'(1);
            use_start = 1'b1;
          end
        end
        MODE_COMMENT: begin
          if (q_head.item.cls == CLS_STAR) begin
            mode_nxt = MODE_CSTAR;
          end
        end
        MODE_CSTAR: begin
          // The closing star is not part of the content.
          if (q_head.item.cls == CLS_SLASH) begin
            pre_v    = 1'b1;
            pre_kind = KIND_COMMENT;
            pre_len  = pend - POS_BITS'(1);
            mode_nxt = MODE_IDLE;
          end else if (q_head.item.cls != CLS_STAR) begin
            mode_nxt = MODE_COMMENT;
          end
        end
        MODE_ERROR: begin
          mode_nxt = MODE_ERROR;
        end
        default: use_start = 1'b1;
      endcase
      if (use_start) begin
        mode_nxt = st_mode;
        if (st_begin_we) begin
          begin_nxt = st_begin;
        end
      end
    end
  end

  // Order the zero, one or two tokens of this word.
  always_comb begin
    pre_tok.kind   = pre_kind;
    pre_tok.start  = low_pos(begin_r);
    pre_tok.length = sat_len(pre_len);
    pre_tok.last   = 1'b0;
    if (q_head.item.cls == CLS_END) begin
      post_v          = 1'b1;
      post_tok.kind   = KIND_END;
      post_tok.length = '0;
    end else begin
      post_v          = use_start && st_v;
      post_tok.kind   = st_kind;
      post_tok.length = TOK_BITS'(1);
    end
    post_tok.start = low_pos(pos_r);
    post_tok.last  = 1'b1;
    two_tok        = pre_v && post_v;
    any_tok        = pre_v || post_v;
    tok0           = pre_v ? pre_tok : post_tok;
    tok0.last      = !two_tok;
    tok1           = post_tok;
  end

  // Take a word when the spill slot is empty and a token it yields has room.
  always_comb begin
    out_free  = !out_valid_r || !out_stall;
    q_pop     = q_head.valid && !spill_valid_r && (!any_tok || out_free);
    out_valid = out_valid_r;
    out_tok   = out_r;
  end

  // Lexer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      begin_r <= '0;
      pos_r   <= '0;
    end else if (q_pop) begin
      mode_r  <= mode_nxt;
      begin_r <= begin_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // Result register and spill slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      spill_valid_r <= 1'b0;
    end else begin
      priority if (spill_valid_r && out_free) begin
        out_r         <= spill_r;
        out_valid_r   <= 1'b1;
        spill_valid_r <= 1'b0;
      end else if (q_pop && any_tok) begin
        out_r         <= tok0;
        out_valid_r   <= 1'b1;
        spill_r       <= tok1;
        spill_valid_r <= two_tok;
      end else begin
        out_valid_r <= out_valid_r && out_stall;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/config_text_tokenizer_top.sv
// Top level of the configuration text tokenizer: front end, queue and back end.
// Depends on ctt_pkg, ctt_front, ctt_back and config_text_tokenizer_top_defines.svh.
//
// Usage: one character word per in_valid/in_stall handshake; in_end_of_stream
// marks the end of a stream and flushes the pending token, then an end token.
// Tokens leave on out_valid/out_stall as kind, start offset, length and a flag
// on the last token caused by one input word.
// A word is written into the queue storage; a token it causes is registered in
// the result register when the back end takes that word from the queue.
// Throughput: one word per cycle while out_stall is low and the spill slot is empty;
// the second token of a word waits in the spill slot, as there is a single result port.
// The front end holds a four-word queue, so input keeps flowing while the
// receiver stalls until that queue fills; then in_stall rises.
// Reset clears the queue, the result register and the lexer, which starts idle
// at offset zero. No payload is lost while out_stall is high: the result
// register and the spill slot hold their tokens.
`default_nettype none
`include "config_text_tokenizer_top_defines.svh"

module config_text_tokenizer_top #(
  parameter int POS_BITS = 24
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_char_byte,
  input  wire         in_end_of_stream,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [3:0]  out_token_kind,
  output logic [23:0] out_token_start,
  output logic [23:0] out_token_length,
  output logic        out_last_of_run
);
  import ctt_pkg::*;

  q_head_t q_head;
  logic    q_pop;
  token_t  out_tok;

  // Front end: classify and queue.
  ctt_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_byte     (in_char_byte),
    .in_end_of_stream (in_end_of_stream),
    .q_head           (q_head),
    .q_pop            (q_pop)
  );

  // Back end: lexer and result register.
  ctt_back #(
    .POS_BITS (POS_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_tok   (out_tok)
  );

  // Result word onto separate ports.
  assign out_token_kind   = out_tok.kind;
  assign out_token_start  = out_tok.start;
  assign out_token_length = out_tok.length;
  assign out_last_of_run  = out_tok.last;

  // The back end only takes words the queue really holds.
  `CTT_ASSERT_NOW(a_pop_has_word, q_pop, q_head.valid, "pop from empty queue")
  // An end token always closes the tokens of its input word.
  `CTT_ASSERT_NOW(a_end_is_last, out_valid && out_token_kind == KIND_END,
                  out_last_of_run && out_token_length == '0, "end token malformed")
  // An error token covers exactly the offending character and ends its word.
  `CTT_ASSERT_NOW(a_error_len, out_valid && out_token_kind == KIND_ERROR,
                  out_token_length == 24'd1 && out_last_of_run, "error token malformed")
  // A result that is not the last of its word is followed by another result.
  `CTT_ASSERT_NEXT(a_run_continues, out_valid && !out_stall && !out_last_of_run,
                   out_valid, "second token of a word missing")

endmodule

`default_nettype wire
